>>> hdl/nrle_pkg.sv
`timescale 1ns / 1ps

package nrle_pkg;

	localparam int GROUP_PIXELS = 16;
	localparam int PIXEL_BITS   = 4;
	localparam int GROUP_BITS   = GROUP_PIXELS * PIXEL_BITS;

	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_TRUNC   = 3'd1;
	localparam logic [2:0] ST_BADSIZE = 3'd2;
	localparam logic [2:0] ST_OVERRUN = 3'd3;
	localparam logic [2:0] ST_NOPREV  = 3'd4;
	localparam logic [2:0] ST_READ    = 3'd5;

	localparam logic [1:0] KIND_LITERAL = 2'b01;
	localparam logic [1:0] KIND_COPY    = 2'b11;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CMD,
		PH_COUNT1,
		PH_COUNT2,
		PH_LITERAL,
		PH_IDLE
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BYTE,
		S_HDR_MUL,
		S_HDR_CHK,
		S_CLEAR,
		S_FILL,
		S_COPY_RD,
		S_COPY_WR,
		S_COPY_TAIL,
		S_LIT_HI,
		S_LIT_LO,
		S_FINISH,
		S_REPORT,
		S_READ,
		S_READ_OUT
	} seq_t;

endpackage

>>> hdl/nrle_if.sv
`timescale 1ns / 1ps

interface nrle_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  data_byte;
	logic        start_of_stream;
	logic        end_of_stream;
	logic [11:0] group_index;

	modport source (output valid, func, data_byte, start_of_stream, end_of_stream,
		group_index, input ready);
	modport sink (input valid, func, data_byte, start_of_stream, end_of_stream,
		group_index, output ready);
endinterface

interface nrle_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] pixel_group;
	logic [15:0] image_width;
	logic [15:0] frame_height;
	logic [16:0] line_stride;
	logic [23:0] bytes_consumed;

	modport source (output valid, status, pixel_group, image_width, frame_height,
		line_stride, bytes_consumed, input ready);
	modport sink (input valid, status, pixel_group, image_width, frame_height,
		line_stride, bytes_consumed, output ready);
endinterface

>>> hdl/nrle_store.sv
`timescale 1ns / 1ps

module nrle_store
	import nrle_pkg::*;
#(
	parameter int ROWS = 4096,
	parameter int RAW  = 12
) (
	input  logic                  clk,
	input  logic [GROUP_PIXELS-1:0] we,
	input  logic [RAW-1:0]        waddr,
	input  logic [GROUP_BITS-1:0] wdata,
	input  logic [RAW-1:0]        raddr,
	output logic [GROUP_BITS-1:0] rdata
);

	logic [GROUP_BITS-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		for (int i = 0; i < GROUP_PIXELS; i++) begin
			if (we[i]) begin
				mem[waddr][i*PIXEL_BITS +: PIXEL_BITS] <= wdata[i*PIXEL_BITS +: PIXEL_BITS];
			end
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/nibble_rle_row_copy_decode.sv
`timescale 1ns / 1ps
// channel | dir | payload
// stream  | in  | func, data_byte, start_of_stream, end_of_stream, group_index
// result  | out | status, pixel_group, image_width, frame_height, line_stride,
//         |     | bytes_consumed
// Runs, copies and literals write one pixel at a time through the store's
// single write port. After the last header byte, a valid frame size clears
// the frame, one 16-pixel row a cycle. Reset clears the sequencer and stream
// state, not working registers; the pixel store is not cleared by reset.
// Input is held off while a result waits on the output.

module nibble_rle_row_copy_decode
	import nrle_pkg::*;
#(
	parameter int STORE_PIXELS = 65536
) (
	input  logic clk,
	input  logic arst_n,
	nrle_in_if.sink    stream,
	nrle_out_if.source result
);

	localparam int ROWS = STORE_PIXELS / GROUP_PIXELS;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int FTW  = $clog2(STORE_PIXELS + 1);
	localparam int CW   = (FTW > 17) ? FTW : 17;

	seq_t   seq_q, seq_d;
	phase_t phase_q;

	logic [15:0]      hw_q, hh_q;
	logic [FTW-1:0]   ft_q, wp_q;
	logic [23:0]      src_q;
	logic [7:0]       held_q, byte_q;
	logic [15:0]      pend_q;
	logic             eos_q;
	logic [CW-1:0]    cnt_q;
	logic [3:0]       colour_q, nib_q;
	logic [32:0]      prod_q;
	logic [RAW-1:0]   clr_q, gi_q;
	logic             rng_q;
	logic [2:0]       stat_q, stat_d;

	logic             out_v_q;
	logic [2:0]       out_status_q;
	logic [63:0]      out_group_q;
	logic [23:0]      out_src_q;

	logic [16:0]      stride;
	logic [CW-1:0]    room, short_n, long_n, src_pos;
	logic             in_fire, out_fire, is_long_exec, wp_in;
	logic [1:0]       kind;

	logic [GROUP_PIXELS-1:0] mem_we;
	logic [RAW-1:0]          mem_waddr, mem_raddr;
	logic [GROUP_BITS-1:0]   mem_wdata, mem_rdata;
	logic [3:0]              copy_pix;

	assign stride    = ({1'b0, hw_q} + 17'd15) & ~17'd15;
	assign room      = CW'(ft_q) - CW'(wp_q);
	assign short_n   = CW'(byte_q[6:4]) + CW'(1);
	assign long_n    = (phase_q == PH_COUNT2) ? CW'({pend_q[7:0], byte_q}) + CW'(1)
		: CW'(byte_q) + CW'(1);
	assign src_pos   = CW'(wp_q) - CW'(stride);
	assign kind      = held_q[5:4];
	assign is_long_exec = (phase_q == PH_COUNT2) || (phase_q == PH_COUNT1 && !held_q[6]);
	assign wp_in     = wp_q < ft_q;
	assign copy_pix  = mem_rdata[nib_q*PIXEL_BITS +: PIXEL_BITS];

	assign stream.ready = (seq_q == S_IDLE) && !out_v_q;
	assign in_fire      = stream.valid && stream.ready;
	assign out_fire     = result.valid && result.ready;

	always_comb begin
		seq_d  = seq_q;
		stat_d = stat_q;
		case (seq_q)
			S_IDLE: begin
				if (in_fire) seq_d = stream.func ? S_READ : S_BYTE;
			end
			S_BYTE: begin
				case (phase_q)
					PH_IDLE: seq_d = S_IDLE;
					PH_HEADER: seq_d = (src_q == 24'd3) ? S_HDR_MUL : S_FINISH;
					PH_LITERAL: seq_d = S_LIT_HI;
					PH_CMD: begin
						if (byte_q[7]) seq_d = S_FINISH;
						else if (short_n > room) begin
							seq_d = S_REPORT;
							stat_d = ST_OVERRUN;
						end else seq_d = S_FILL;
					end
					default: begin
						if (!is_long_exec) seq_d = S_FINISH;
						else if (kind == KIND_COPY && CW'(wp_q) < CW'(stride)) begin
							seq_d = S_REPORT;
							stat_d = ST_NOPREV;
						end else if (long_n > room) begin
							seq_d = S_REPORT;
							stat_d = ST_OVERRUN;
						end else if (kind == KIND_COPY) seq_d = S_COPY_RD;
						else if (kind == KIND_LITERAL) seq_d = long_n[0] ? S_FILL : S_FINISH;
						else seq_d = S_FILL;
					end
				endcase
			end
			S_HDR_MUL: seq_d = S_HDR_CHK;
			S_HDR_CHK: begin
				if (hw_q == 16'd0 || hh_q == 16'd0 || prod_q > 33'(STORE_PIXELS)) begin
					seq_d = S_REPORT;
					stat_d = ST_BADSIZE;
				end else seq_d = S_CLEAR;
			end
			S_CLEAR: begin
				if (32'(clr_q) == 32'(ft_q >> 4) - 32'd1) seq_d = S_FINISH;
			end
			S_FILL: begin
				if (cnt_q == CW'(1)) seq_d = S_FINISH;
			end
			S_COPY_RD: seq_d = S_COPY_WR;
			S_COPY_WR: seq_d = (cnt_q == CW'(1)) ? S_COPY_TAIL : S_COPY_RD;
			S_COPY_TAIL: begin
				if (wp_q == ft_q) begin
					seq_d = S_REPORT;
					stat_d = ST_OVERRUN;
				end else seq_d = S_FILL;
			end
			S_LIT_HI: seq_d = S_LIT_LO;
			S_LIT_LO: seq_d = S_FINISH;
			S_FINISH: begin
				if (phase_q == PH_CMD && wp_q == ft_q) begin
					seq_d = S_REPORT;
					stat_d = ST_DONE;
				end else if (eos_q) begin
					seq_d = S_REPORT;
					stat_d = ST_TRUNC;
				end else seq_d = S_IDLE;
			end
			S_REPORT: seq_d = S_IDLE;
			S_READ: seq_d = S_READ_OUT;
			S_READ_OUT: seq_d = S_IDLE;
			default: seq_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = '0;
		mem_waddr = RAW'(wp_q >> 4);
		mem_wdata = {GROUP_PIXELS{colour_q}};
		mem_raddr = gi_q;
		case (seq_q)
			S_CLEAR: begin
				mem_we    = '1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_FILL: begin
				if (wp_in) mem_we = GROUP_PIXELS'(1) << wp_q[3:0];
			end
			S_COPY_RD: mem_raddr = RAW'(src_pos >> 4);
			S_COPY_WR: begin
				if (wp_in) mem_we = GROUP_PIXELS'(1) << wp_q[3:0];
				mem_wdata = {GROUP_PIXELS{copy_pix}};
			end
			S_LIT_HI: begin
				if (wp_in) mem_we = GROUP_PIXELS'(1) << wp_q[3:0];
				mem_wdata = {GROUP_PIXELS{byte_q[7:4]}};
			end
			S_LIT_LO: begin
				if (wp_in) mem_we = GROUP_PIXELS'(1) << wp_q[3:0];
				mem_wdata = {GROUP_PIXELS{byte_q[3:0]}};
			end
			default: mem_we = '0;
		endcase
	end

	nrle_store #(
		.ROWS (ROWS),
		.RAW  (RAW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= S_IDLE;
			phase_q <= PH_HEADER;
			hw_q    <= '0;
			hh_q    <= '0;
			ft_q    <= '0;
			wp_q    <= '0;
			src_q   <= '0;
			held_q  <= '0;
			pend_q  <= '0;
			out_v_q <= 1'b0;
			stat_q  <= ST_DONE;
		end else begin
			seq_q  <= seq_d;
			stat_q <= stat_d;
			if (out_fire) out_v_q <= 1'b0;
			case (seq_q)
				S_IDLE: begin
					if (in_fire && !stream.func && stream.start_of_stream) begin
						phase_q <= PH_HEADER;
						hw_q    <= '0;
						hh_q    <= '0;
						ft_q    <= '0;
						wp_q    <= '0;
						src_q   <= '0;
						held_q  <= '0;
						pend_q  <= '0;
					end
				end
				S_BYTE: begin
					if (phase_q != PH_IDLE) src_q <= src_q + 24'd1;
					case (phase_q)
						PH_HEADER: begin
							if (src_q == 24'd0) hw_q <= {byte_q, 8'd0};
							else if (src_q == 24'd1) hw_q[7:0] <= byte_q;
							else if (src_q == 24'd2) hh_q <= {byte_q, 8'd0};
							else hh_q[7:0] <= byte_q;
						end
						PH_CMD: begin
							if (byte_q[7]) begin
								held_q  <= byte_q;
								phase_q <= PH_COUNT1;
							end
						end
						PH_COUNT1, PH_COUNT2: begin
							if (phase_q == PH_COUNT1 && held_q[6]) begin
								pend_q  <= {pend_q[7:0], byte_q};
								phase_q <= PH_COUNT2;
							end else if (kind == KIND_LITERAL && (long_n >> 1) != CW'(0)) begin
								pend_q  <= 16'(long_n >> 1);
								phase_q <= PH_LITERAL;
							end else phase_q <= PH_CMD;
						end
						default: phase_q <= phase_q;
					endcase
				end
				S_HDR_CHK: begin
					if (seq_d == S_CLEAR) begin
						ft_q    <= FTW'(prod_q);
						phase_q <= PH_CMD;
					end
				end
				S_FILL, S_COPY_WR, S_LIT_HI: wp_q <= wp_q + FTW'(1);
				S_LIT_LO: begin
					wp_q   <= wp_q + FTW'(1);
					pend_q <= pend_q - 16'd1;
					if (pend_q == 16'd1) phase_q <= PH_CMD;
				end
				S_REPORT: begin
					phase_q <= PH_IDLE;
					out_v_q <= 1'b1;
				end
				S_READ_OUT: out_v_q <= 1'b1;
				default: phase_q <= phase_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (seq_q)
			S_IDLE: begin
				if (in_fire) begin
					byte_q <= stream.data_byte;
					eos_q  <= stream.end_of_stream;
					gi_q   <= RAW'(stream.group_index);
					rng_q  <= 32'(stream.group_index) < 32'(ft_q >> 4);
				end
			end
			S_BYTE: begin
				if (phase_q == PH_CMD) begin
					cnt_q    <= short_n;
					colour_q <= byte_q[3:0];
				end else begin
					cnt_q    <= (kind == KIND_COPY || kind != KIND_LITERAL) ? long_n : CW'(1);
					colour_q <= held_q[3:0];
				end
			end
			S_HDR_MUL: prod_q <= 33'(stride) * 33'(hh_q);
			S_HDR_CHK: clr_q <= '0;
			S_CLEAR: clr_q <= clr_q + RAW'(1);
			S_FILL: cnt_q <= cnt_q - CW'(1);
			S_COPY_RD: nib_q <= src_pos[3:0];
			S_COPY_WR: cnt_q <= cnt_q - CW'(1);
			S_COPY_TAIL: cnt_q <= CW'(1);
			S_REPORT: begin
				out_status_q <= stat_q;
				out_group_q  <= '0;
				out_src_q    <= src_q;
			end
			S_READ_OUT: begin
				out_status_q <= ST_READ;
				out_group_q  <= rng_q ? mem_rdata : '0;
				out_src_q    <= src_q;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	assign result.valid          = out_v_q;
	assign result.status         = out_status_q;
	assign result.pixel_group    = out_group_q;
	assign result.image_width    = hw_q;
	assign result.frame_height   = hh_q;
	assign result.line_stride    = stride;
	assign result.bytes_consumed = out_src_q;

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> !stream.ready)
		else $error("input taken while a result waits");

	a_report_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == S_REPORT |=> phase_q == PH_IDLE && out_v_q)
		else $error("report did not stop decoding");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= ft_q)
		else $error("write position beyond frame");

endmodule
